// ----- hdl/iarb_pkg.sv -----
// ----------------------------------------------------------------------------
// iarb_pkg
// Shared types, codes and lookup tables of the ADC register block.
// ----------------------------------------------------------------------------
package iarb_pkg;

  localparam int AinW = 23;
  localparam int CntW = 17;

  // bus item codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // register pointer codes
  localparam logic [1:0] PTR_CONV = 2'd0;
  localparam logic [1:0] PTR_CFG  = 2'd1;
  localparam logic [1:0] PTR_LO   = 2'd2;
  localparam logic [1:0] PTR_HI   = 2'd3;

  localparam logic [15:0] CFG_RESET = 16'h8583;
  localparam logic [15:0] LO_RESET  = 16'h8000;
  localparam logic [15:0] HI_RESET  = 16'h7FFF;

  localparam logic [CntW-1:0] PERIOD_MIN = CntW'(200);

  // input pair per mux code; a negative index of 4 means ground
  localparam logic [1:0] PAIR_POS [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [2:0] PAIR_NEG [8] = '{3'd1, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4};
  localparam logic [2:0] GND_SEL = 3'd4;

  typedef struct packed {
    logic [1:0]      operation;
    logic [7:0]      write_byte;
    logic [AinW-1:0] ain0_microvolts;
    logic [AinW-1:0] ain1_microvolts;
    logic [AinW-1:0] ain2_microvolts;
    logic [AinW-1:0] ain3_microvolts;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic               conversion_done;
    logic               busy_res;
    logic signed [15:0] new_code;
  } out_word_t;

  // full scale in microvolts from the gain field
  function automatic logic [AinW-1:0] full_scale(input logic [2:0] sel);
    logic [AinW-1:0] fs;
    case (sel)
      3'd0:    fs = AinW'(6144000);
      3'd1:    fs = AinW'(4096000);
      3'd2:    fs = AinW'(2048000);
      3'd3:    fs = AinW'(1024000);
      3'd4:    fs = AinW'(512000);
      default: fs = AinW'(256000);
    endcase
    return fs;
  endfunction

  // sample period in microseconds from the rate field (1e6 / rate, truncated)
  function automatic logic [CntW-1:0] period_us(input logic [2:0] rate);
    logic [CntW-1:0] p;
    case (rate)
      3'd0:    p = CntW'(125000);
      3'd1:    p = CntW'(62500);
      3'd2:    p = CntW'(31250);
      3'd3:    p = CntW'(15625);
      3'd4:    p = CntW'(7812);
      3'd5:    p = CntW'(4000);
      3'd6:    p = CntW'(2105);
      default: p = CntW'(1162);
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/iarb_stream_if.sv -----
// ----------------------------------------------------------------------------
// iarb_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface iarb_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/i2c_adc_register_block_top.sv -----
// ----------------------------------------------------------------------------
// i2c_adc_register_block_top
// Register file and conversion engine of a four-input 16-bit ADC.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word. Bus start, write, read and
// ticks that do not end a conversion are handled in the idle state and their word is
// registered on the output the next cycle. A tick that ends a conversion
// runs through the conversion states before its output word: one shared 41-bit
// add/subtract unit forms the pair difference, magnitude, clamp and scaled
// numerator in five steps, then runs a 16-step restoring divide by twice the
// full scale. in_s.ready is low while that runs and while an unread output
// word is held. No clearing pass after reset.
module i2c_adc_register_block_top (
  input  logic       clk,
  input  logic       rst_n,
  iarb_stream_if.sink   in_s,
  iarb_stream_if.source out_m
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_ABS, S_CLAMP, S_MUL1, S_MUL2, S_DIV, S_FIN
  } state_t;

  localparam int AccW = 41;
  localparam int AinW = iarb_pkg::AinW;
  localparam int CntW = iarb_pkg::CntW;

  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  iarb_pkg::out_word_t  out_data_r, out_data_nxt;

  logic [1:0]           pointer_r, pointer_nxt;
  logic                 ptr_rcvd_r, ptr_rcvd_nxt;
  logic                 byte_cnt_r, byte_cnt_nxt;
  logic [7:0]           first_byte_r, first_byte_nxt;
  logic                 read_half_r, read_half_nxt;
  logic [15:0]          conv_r, conv_nxt;
  logic [15:0]          config_r, config_nxt;
  logic [15:0]          lo_thr_r, lo_thr_nxt;
  logic [15:0]          hi_thr_r, hi_thr_nxt;
  logic                 converting_r, converting_nxt;
  logic [CntW-1:0]      countdown_r, countdown_nxt;

  // conversion datapath
  logic [AinW-1:0]      vpos_r, vpos_nxt;
  logic [AinW-1:0]      vneg_r, vneg_nxt;
  logic [AinW-1:0]      fs_r, fs_nxt;
  logic                 neg_r, neg_nxt;
  logic [AccW-1:0]      acc_r, acc_nxt;
  logic [AccW-2:0]      dsh_r, dsh_nxt;
  logic [15:0]          q_r, q_nxt;
  logic [3:0]           cnt_r, cnt_nxt;

  // shared add/subtract unit
  logic [AccW-1:0]      alu_a, alu_b, alu_y;
  logic                 alu_sub;

  logic                 in_fire;
  logic [AinW-1:0]      ain [4];
  logic [15:0]          wr_value;
  logic [15:0]          rd_reg;
  logic [CntW-1:0]      per;
  logic [2:0]           mux_sel;
  logic [2:0]           neg_sel;
  logic [15:0]          code;
  logic [15:0]          cfg_done;

  assign in_s.ready  = (state_r == S_IDLE) && (!out_valid_r || out_m.ready);
  assign in_fire     = in_s.valid && in_s.ready;
  assign out_m.valid = out_valid_r;
  assign out_m.data  = out_data_r;

  assign ain[0] = in_s.data.ain0_microvolts;
  assign ain[1] = in_s.data.ain1_microvolts;
  assign ain[2] = in_s.data.ain2_microvolts;
  assign ain[3] = in_s.data.ain3_microvolts;

  assign wr_value = {first_byte_r, in_s.data.write_byte};
  assign mux_sel  = config_r[14:12];
  assign neg_sel  = iarb_pkg::PAIR_NEG[mux_sel];
  assign code     = neg_r ? (16'd0 - q_r) : q_r;
  assign cfg_done = config_r | 16'h8000;

  always_comb begin
    case (pointer_r)
      iarb_pkg::PTR_CONV: rd_reg = conv_r;
      iarb_pkg::PTR_CFG:  rd_reg = config_r;
      iarb_pkg::PTR_LO:   rd_reg = lo_thr_r;
      default:            rd_reg = hi_thr_r;
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      S_DIFF: begin
        alu_a = AccW'(vpos_r);
        alu_b = AccW'(vneg_r);
      end
      S_ABS: begin
        alu_a = '0;
        alu_b = acc_r;
      end
      S_CLAMP: begin
        alu_a = AccW'(fs_r);
        alu_b = acc_r;
      end
      S_MUL1: begin
        // x * 65534 = (x << 16) - (x << 1)
        alu_a = {acc_r[AccW-17:0], 16'd0};
        alu_b = {acc_r[AccW-2:0], 1'b0};
      end
      S_MUL2: begin
        alu_b   = AccW'(fs_r);
        alu_sub = 1'b0;
      end
      S_DIV: begin
        alu_b = AccW'(dsh_r);
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + AccW'(alu_sub);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_m.ready;
    out_data_nxt   = out_data_r;
    pointer_nxt    = pointer_r;
    ptr_rcvd_nxt   = ptr_rcvd_r;
    byte_cnt_nxt   = byte_cnt_r;
    first_byte_nxt = first_byte_r;
    read_half_nxt  = read_half_r;
    conv_nxt       = conv_r;
    config_nxt     = config_r;
    lo_thr_nxt     = lo_thr_r;
    hi_thr_nxt     = hi_thr_r;
    converting_nxt = converting_r;
    countdown_nxt  = countdown_r;
    vpos_nxt       = vpos_r;
    vneg_nxt       = vneg_r;
    fs_nxt         = fs_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    dsh_nxt        = dsh_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    per            = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_data_nxt = '0;
          case (in_s.data.operation)
            iarb_pkg::OP_START: begin
              read_half_nxt = 1'b0;
              ptr_rcvd_nxt  = 1'b0;
              byte_cnt_nxt  = 1'b0;
            end
            iarb_pkg::OP_WRITE: begin
              if (!ptr_rcvd_r) begin
                pointer_nxt  = in_s.data.write_byte[1:0];
                ptr_rcvd_nxt = 1'b1;
                byte_cnt_nxt = 1'b0;
              end else if (!byte_cnt_r) begin
                first_byte_nxt = in_s.data.write_byte;
                byte_cnt_nxt   = 1'b1;
              end else begin
                byte_cnt_nxt = 1'b0;
                case (pointer_r)
                  iarb_pkg::PTR_CFG: begin
                    config_nxt = wr_value;
                    if (wr_value[15] && !converting_r) begin
                      converting_nxt = 1'b1;
                      config_nxt[15] = 1'b0;
                      per            = iarb_pkg::period_us(wr_value[7:5]);
                      countdown_nxt  = (per < iarb_pkg::PERIOD_MIN) ?
                                       iarb_pkg::PERIOD_MIN : per;
                    end
                  end
                  iarb_pkg::PTR_LO: lo_thr_nxt = wr_value;
                  iarb_pkg::PTR_HI: hi_thr_nxt = wr_value;
                  default: ;  // conversion register is read only
                endcase
              end
            end
            iarb_pkg::OP_READ: begin
              out_data_nxt.read_byte = read_half_r ? rd_reg[7:0] : rd_reg[15:8];
              read_half_nxt          = !read_half_r;
            end
            default: begin
              if (converting_r) begin
                if (countdown_r > CntW'(1)) begin
                  countdown_nxt = countdown_r - CntW'(1);
                end else begin
                  // expiry: latch the pair and full scale from this tick
                  vpos_nxt = ain[iarb_pkg::PAIR_POS[mux_sel]];
                  vneg_nxt = (neg_sel == iarb_pkg::GND_SEL) ? '0 : ain[neg_sel[1:0]];
                  fs_nxt   = iarb_pkg::full_scale(config_r[11:9]);
                  state_nxt = S_DIFF;
                end
              end
            end
          endcase
          if (state_nxt == S_IDLE) begin
            out_data_nxt.busy_res = converting_nxt;
            out_valid_nxt         = 1'b1;
          end
        end
      end
      S_DIFF: begin
        acc_nxt   = alu_y;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt = acc_r[AccW-1];
        if (acc_r[AccW-1]) acc_nxt = alu_y;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // fs - |d| negative means |d| > fs
        if (alu_y[AccW-1]) acc_nxt = AccW'(fs_r);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        acc_nxt   = alu_y;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = alu_y;
        dsh_nxt   = (AccW-1)'(fs_r) << 16;  // (2 * fs) << 15
        q_nxt     = '0;
        cnt_nxt   = 4'd15;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!alu_y[AccW-1]) acc_nxt = alu_y;
        q_nxt   = {q_r[14:0], !alu_y[AccW-1]};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) state_nxt = S_FIN;
      end
      S_FIN: begin
        conv_nxt   = code;
        config_nxt = cfg_done;
        if (!cfg_done[8]) begin
          // continuous mode restarts at once
          converting_nxt = 1'b1;
          config_nxt[15] = 1'b0;
          countdown_nxt  = iarb_pkg::period_us(cfg_done[7:5]);
        end else begin
          converting_nxt = 1'b0;
          countdown_nxt  = '0;
        end
        out_data_nxt.read_byte       = 8'd0;
        out_data_nxt.conversion_done = 1'b1;
        out_data_nxt.busy_res        = !cfg_done[8];
        out_data_nxt.new_code        = code;
        out_valid_nxt                = 1'b1;
        state_nxt                    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pointer_r    <= 2'd0;
      ptr_rcvd_r   <= 1'b0;
      byte_cnt_r   <= 1'b0;
      first_byte_r <= 8'd0;
      read_half_r  <= 1'b0;
      conv_r       <= 16'd0;
      config_r     <= iarb_pkg::CFG_RESET;
      lo_thr_r     <= iarb_pkg::LO_RESET;
      hi_thr_r     <= iarb_pkg::HI_RESET;
      converting_r <= 1'b0;
      countdown_r  <= '0;
      cnt_r        <= 4'd0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pointer_r    <= pointer_nxt;
      ptr_rcvd_r   <= ptr_rcvd_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      first_byte_r <= first_byte_nxt;
      read_half_r  <= read_half_nxt;
      conv_r       <= conv_nxt;
      config_r     <= config_nxt;
      lo_thr_r     <= lo_thr_nxt;
      hi_thr_r     <= hi_thr_nxt;
      converting_r <= converting_nxt;
      countdown_r  <= countdown_nxt;
      cnt_r        <= cnt_nxt;
    end
    out_data_r <= out_data_nxt;
    vpos_r     <= vpos_nxt;
    vneg_r     <= vneg_nxt;
    fs_r       <= fs_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    dsh_r      <= dsh_nxt;
    q_r        <= q_nxt;
  end

endmodule

// ----- hdl/iarb_checker.sv -----
// ----------------------------------------------------------------------------
// iarb_checker
// Port-level checks of the ADC register block, bound to the top level.
// ----------------------------------------------------------------------------
module iarb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_op,
  input logic                out_valid,
  input logic                out_ready,
  input iarb_pkg::out_word_t out_data
);

  // non-tick words are answered on the next cycle
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != iarb_pkg::OP_TICK) |=> out_valid)
    else $error("bus word not answered next cycle");

  // a held output word blocks new input
  a_out_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output word is stalled");

  a_code_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.conversion_done |-> out_data.new_code == 16'sd0)
    else $error("code reported without a finished conversion");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind i2c_adc_register_block_top iarb_checker u_iarb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_op     (in_s.data.operation),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_data  (out_m.data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the ADC register block. Bus starts, pointer and data bytes,
// reads and microsecond ticks go in as words. A predictor tracks pointer,
// registers and countdown and computes every output word, which is checked
// field by field as it leaves the block. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 20_000;
  localparam int unsigned UV_FULL_SCALE [8] =
    '{6144000, 4096000, 2048000, 1024000, 512000, 256000, 256000, 256000};
  localparam int unsigned SPS_TABLE [8] = '{8, 16, 32, 64, 128, 250, 475, 860};

  logic clk = 1'b0;
  logic rst_n;

  iarb_stream_if #(.word_t(iarb_pkg::in_word_t))  in_s ();
  iarb_stream_if #(.word_t(iarb_pkg::out_word_t)) out_m ();

  i2c_adc_register_block_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_m (out_m)
  );

  always #6 clk = ~clk;

  // predicted register state
  logic [1:0]  reg_sel    = iarb_pkg::PTR_CONV;
  logic        sel_seen   = 1'b0;
  logic        data_phase = 1'b0;
  logic [7:0]  msb_hold   = 8'h00;
  logic        lsb_next   = 1'b0;
  logic [15:0] conv_code  = 16'h0000;
  logic [15:0] cfg_word   = iarb_pkg::CFG_RESET;
  logic [15:0] thr_lo     = iarb_pkg::LO_RESET;
  logic [15:0] thr_hi     = iarb_pkg::HI_RESET;
  logic        busy       = 1'b0;
  int          us_left    = 0;

  iarb_pkg::out_word_t adc_words_due[$];
  int        err_count = 0;
  int        hold_off  = 0;
  logic      no_gaps   = 1'b0;

  task automatic note_mismatch(input string what, input longint got, input longint want);
    if (err_count < 100)
      $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int sample_period();
    return 1000000 / SPS_TABLE[cfg_word[7:5]];
  endfunction

  function automatic iarb_pkg::out_word_t predict_adc_word(input iarb_pkg::in_word_t w);
    iarb_pkg::out_word_t r;
    logic [15:0] v;
    longint      pos, neg_v, d, fs, mag, q;
    r = '0;
    case (w.operation)
      iarb_pkg::OP_START: begin
        lsb_next   = 1'b0;
        sel_seen   = 1'b0;
        data_phase = 1'b0;
      end
      iarb_pkg::OP_WRITE: begin
        if (!sel_seen) begin
          reg_sel    = w.write_byte[1:0];
          sel_seen   = 1'b1;
          data_phase = 1'b0;
        end else if (!data_phase) begin
          msb_hold   = w.write_byte;
          data_phase = 1'b1;
        end else begin
          data_phase = 1'b0;
          v = {msb_hold, w.write_byte};
          case (reg_sel)
            iarb_pkg::PTR_CFG: begin
              cfg_word = v;
              if (v[15] && !busy) begin
                busy        = 1'b1;
                cfg_word[15] = 1'b0;
                us_left     = (sample_period() < 200) ? 200 : sample_period();
              end
            end
            iarb_pkg::PTR_LO:  thr_lo = v;
            iarb_pkg::PTR_HI:  thr_hi = v;
            default: ;  // conversion register is read-only
          endcase
        end
      end
      iarb_pkg::OP_READ: begin
        case (reg_sel)
          iarb_pkg::PTR_CONV: v = conv_code;
          iarb_pkg::PTR_CFG:  v = cfg_word;
          iarb_pkg::PTR_LO:   v = thr_lo;
          default:            v = thr_hi;
        endcase
        r.read_byte = lsb_next ? v[7:0] : v[15:8];
        lsb_next = ~lsb_next;
      end
      default: begin
        if (busy) begin
          if (us_left > 1) begin
            us_left--;
          end else begin
            us_left = 0;
            case (cfg_word[14:12])
              3'd0: begin pos = w.ain0_microvolts; neg_v = w.ain1_microvolts; end
              3'd1: begin pos = w.ain0_microvolts; neg_v = w.ain3_microvolts; end
              3'd2: begin pos = w.ain1_microvolts; neg_v = w.ain3_microvolts; end
              3'd3: begin pos = w.ain2_microvolts; neg_v = w.ain3_microvolts; end
              3'd4: begin pos = w.ain0_microvolts; neg_v = 0; end
              3'd5: begin pos = w.ain1_microvolts; neg_v = 0; end
              3'd6: begin pos = w.ain2_microvolts; neg_v = 0; end
              default: begin pos = w.ain3_microvolts; neg_v = 0; end
            endcase
            fs = UV_FULL_SCALE[cfg_word[11:9]];
            d = pos - neg_v;
            if (d > fs) d = fs;
            if (d < -fs) d = -fs;
            mag = (d < 0) ? -d : d;
            // nearest code, halves away from zero
            q = (2 * mag * 32767 + fs) / (2 * fs);
            if (d < 0) q = -q;
            conv_code = q[15:0];
            r.new_code = conv_code;
            r.conversion_done = 1'b1;
            busy = 1'b0;
            cfg_word[15] = 1'b1;
            if (!cfg_word[8]) begin
              busy = 1'b1;
              cfg_word[15] = 1'b0;
              us_left = sample_period();
            end
          end
        end
      end
    endcase
    r.busy_res = busy;
    return r;
  endfunction

  function automatic logic [22:0] rand_ain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 23'($urandom);
      default: return 23'($urandom_range(5000000));
    endcase
  endfunction

  function automatic logic [15:0] cfg_value(input logic go, input logic [2:0] mux,
                                            input logic [2:0] pga, input logic single,
                                            input logic [2:0] dr);
    return {go, mux, pga, single, dr, 5'($urandom)};
  endfunction

  // called at a rising edge; returns at the edge the word is taken
  task automatic send_word(input iarb_pkg::in_word_t w);
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_s.valid <= 1'b0;
      @(posedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.data  <= w;
    do @(posedge clk); while (!in_s.ready);
    adc_words_due.push_back(predict_adc_word(w));
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    iarb_pkg::in_word_t w;
    w.operation       = op;
    w.write_byte      = b;
    w.ain0_microvolts = rand_ain();
    w.ain1_microvolts = rand_ain();
    w.ain2_microvolts = rand_ain();
    w.ain3_microvolts = rand_ain();
    send_word(w);
  endtask

  task automatic bus_write16(input logic [1:0] ptr, input logic [15:0] val);
    send_op(iarb_pkg::OP_START, 8'($urandom));
    send_op(iarb_pkg::OP_WRITE, {6'($urandom), ptr});
    send_op(iarb_pkg::OP_WRITE, val[15:8]);
    send_op(iarb_pkg::OP_WRITE, val[7:0]);
  endtask

  task automatic bus_read16(input logic [1:0] ptr, input int n);
    send_op(iarb_pkg::OP_START, 8'($urandom));
    send_op(iarb_pkg::OP_WRITE, {6'($urandom), ptr});
    repeat (n) send_op(iarb_pkg::OP_READ, 8'($urandom));
  endtask

  // tick down the running conversion; the final tick carries the given inputs
  task automatic tick_to_expiry(input logic [22:0] a0, input logic [22:0] a1,
                                input logic [22:0] a2, input logic [22:0] a3);
    iarb_pkg::in_word_t w;
    while (busy && us_left > 1) send_op(iarb_pkg::OP_TICK, 8'($urandom));
    if (busy) begin
      w.operation       = iarb_pkg::OP_TICK;
      w.write_byte      = 8'($urandom);
      w.ain0_microvolts = a0;
      w.ain1_microvolts = a1;
      w.ain2_microvolts = a2;
      w.ain3_microvolts = a3;
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    in_s.valid <= 1'b0;
    do @(posedge clk); while (adc_words_due.size() != 0);
  endtask

  task automatic test_reset_readback();
    bus_read16(iarb_pkg::PTR_CONV, 2);
    bus_read16(iarb_pkg::PTR_CFG, 3);  // third read wraps to the high byte again
    send_op(iarb_pkg::OP_TICK, 8'hFF); // idle tick does nothing
    bus_read16(iarb_pkg::PTR_HI, 2);
  endtask

  task automatic test_bus_framing();
    bus_write16(iarb_pkg::PTR_LO, 16'h0000);
    bus_write16(iarb_pkg::PTR_HI, 16'hFFFF);
    // start keeps the pointer
    send_op(iarb_pkg::OP_START, 8'h00);
    send_op(iarb_pkg::OP_READ, 8'h00);
    send_op(iarb_pkg::OP_READ, 8'hFF);
    bus_write16(iarb_pkg::PTR_CONV, 16'h1234);
    bus_read16(iarb_pkg::PTR_CONV, 2);
    // start in the middle of a data pair drops the half word
    send_op(iarb_pkg::OP_START, 8'h00);
    send_op(iarb_pkg::OP_WRITE, 8'hFE);
    send_op(iarb_pkg::OP_WRITE, 8'h5A);
    send_op(iarb_pkg::OP_START, 8'hFF);
    send_op(iarb_pkg::OP_READ, 8'h00);
    send_op(iarb_pkg::OP_READ, 8'h00);
  endtask

  // one continuous conversion at the fastest rate, reconfigured while busy
  task automatic test_conversion();
    bus_write16(iarb_pkg::PTR_CFG, cfg_value(1'b1, 3'd4, 3'd2, 1'b0, 3'd7));
    bus_read16(iarb_pkg::PTR_CFG, 2);
    no_gaps = 1'b1;
    repeat (400) send_op(iarb_pkg::OP_TICK, 8'($urandom));
    no_gaps = 1'b0;
    // start bit while busy is stored as is; the running countdown is kept,
    // pair and gain at expiry come from this word
    bus_write16(iarb_pkg::PTR_CFG, cfg_value(1'b1, 3'd0, 3'd5, 1'b0, 3'd7));
    bus_read16(iarb_pkg::PTR_CFG, 2);
    // minus half of full scale: the code rounds away from zero
    tick_to_expiry(23'd0, 23'd128000, rand_ain(), rand_ain());
    bus_read16(iarb_pkg::PTR_CFG, 2);
    bus_read16(iarb_pkg::PTR_CONV, 2);
    repeat (2) send_op(iarb_pkg::OP_TICK, 8'($urandom));
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (40) send_op(2'($urandom_range(0, 2)), 8'($urandom));
    wait_drained();
    repeat (20) send_op(2'($urandom), 8'($urandom));
  endtask

  task automatic test_random_traffic();
    int          kind;
    int          n;
    logic [1:0]  ptr;
    logic [15:0] val;
    for (int t = 0; t < 20; t++) begin
      no_gaps = (t < 6);
      kind = $urandom_range(99);
      if (kind < 35) begin
        ptr = 2'($urandom);
        if (ptr == iarb_pkg::PTR_CFG)
          val = cfg_value(1'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                          3'($urandom));
        else
          val = 16'($urandom);
        send_op(iarb_pkg::OP_START, 8'($urandom));
        send_op(iarb_pkg::OP_WRITE, {6'($urandom), ptr});
        // mostly a full pair, sometimes cut short or with a stray byte
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 3) : 2;
        if (n > 0) send_op(iarb_pkg::OP_WRITE, val[15:8]);
        if (n > 1) send_op(iarb_pkg::OP_WRITE, val[7:0]);
        if (n > 2) send_op(iarb_pkg::OP_WRITE, 8'($urandom));
      end else if (kind < 65) begin
        send_op(iarb_pkg::OP_START, 8'($urandom));
        if ($urandom_range(3) != 0) send_op(iarb_pkg::OP_WRITE, 8'($urandom));
        repeat ($urandom_range(1, 4)) send_op(iarb_pkg::OP_READ, 8'($urandom));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 5)) send_op(iarb_pkg::OP_TICK, 8'($urandom));
      end else begin
        send_op(2'($urandom), 8'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin : sink_side
    out_m.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_m.ready <= 1'b0;
        hold_off--;
      end else begin
        out_m.ready <= no_gaps || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin : check_out
    iarb_pkg::out_word_t want;
    if (rst_n && out_m.valid && out_m.ready) begin
      if (adc_words_due.size() == 0) begin
        note_mismatch("unexpected word", out_m.data, 0);
      end else begin
        want = adc_words_due.pop_front();
        if (out_m.data.read_byte !== want.read_byte)
          note_mismatch("read_byte", out_m.data.read_byte, want.read_byte);
        if (out_m.data.conversion_done !== want.conversion_done)
          note_mismatch("conversion_done", out_m.data.conversion_done,
                        want.conversion_done);
        if (out_m.data.busy_res !== want.busy_res)
          note_mismatch("busy_res", out_m.data.busy_res, want.busy_res);
        if (out_m.data.new_code !== want.new_code)
          note_mismatch("new_code", out_m.data.new_code, want.new_code);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : run_tests
    rst_n      = 1'b0;
    in_s.valid = 1'b0;
    in_s.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_readback();
    test_bus_framing();
    test_backpressure();
    test_conversion();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    if (adc_words_due.size() != 0)
      note_mismatch("words never seen", adc_words_due.size(), 0);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
